[rtl/core/sbas_pkg.sv]
// Shared types and constants of the signed BCD add/subtract unit.
// No dependencies; every other file but sbas_carry_tree refers to it by scoped name.
`default_nettype none

package sbas_pkg;

  localparam int WORD_W     = 64;  // packed BCD word on the ports
  localparam int DIGIT_W    = 4;   // one BCD digit
  localparam int MAX_DIGITS = WORD_W / DIGIT_W;
  localparam int SUM_W      = DIGIT_W + 1;

  localparam logic [SUM_W-1:0] DEC_BASE = SUM_W'(10);
  localparam logic [SUM_W-1:0] DEC_NINE = SUM_W'(9);

  // Per-digit carry/borrow terms produced by a front lane.
  typedef struct packed {
    logic add_g;  // digit sum of ten or more: carry regardless of carry in
    logic add_p;  // digit sum of nine: pass carry in
    logic lt;     // a digit below b digit: borrow for a - b
    logic eq;     // equal digits: pass borrow
  } gp_t;

endpackage

`default_nettype wire

[rtl/core/sbas_if.sv]
// Request and result channels of the signed BCD add/subtract unit.
// Depends on sbas_pkg for the word width.
`default_nettype none

interface sbas_op_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [sbas_pkg::WORD_W-1:0] a_digits;
  logic                        a_negative;
  logic [sbas_pkg::WORD_W-1:0] b_digits;
  logic                        b_negative;

  modport source (output valid, action, a_digits, a_negative, b_digits, b_negative,
                  input ready);
  modport sink   (input valid, action, a_digits, a_negative, b_digits, b_negative,
                  output ready);
endinterface

interface sbas_res_if;
  logic                        valid;
  logic                        ready;
  logic [sbas_pkg::WORD_W-1:0] sum_digits;
  logic                        sum_negative;
  logic                        overflow;

  modport source (output valid, sum_digits, sum_negative, overflow, input ready);
  modport sink   (input valid, sum_digits, sum_negative, overflow, output ready);
endinterface

`default_nettype wire

[rtl/core/sbas_lane_gp.sv]
// Front digit lane: carry and borrow generate/propagate terms of one digit.
// Depends on sbas_pkg.
`default_nettype none

module sbas_lane_gp (
  input  wire logic [sbas_pkg::DIGIT_W-1:0] x,
  input  wire logic [sbas_pkg::DIGIT_W-1:0] y,
  output sbas_pkg::gp_t                     gp
);

  logic [sbas_pkg::SUM_W-1:0] raw_sum;

  assign raw_sum  = {1'b0, x} + {1'b0, y};
  assign gp.add_g = raw_sum >= sbas_pkg::DEC_BASE;
  assign gp.add_p = raw_sum == sbas_pkg::DEC_NINE;
  assign gp.lt    = x < y;
  assign gp.eq    = x == y;

endmodule

`default_nettype wire

[rtl/core/sbas_carry_tree.sv]
// Parallel-prefix merge of per-digit generate/propagate into digit carries.
// Standalone; carry[i] is the carry into digit i, carry[N] the carry out.
`default_nettype none

module sbas_carry_tree #(
  parameter int N = 16
) (
  input  wire logic [N-1:0] g,
  input  wire logic [N-1:0] p,
  output logic [N:0]        carry
);

  localparam int LVLS = (N > 1) ? $clog2(N) : 0;

  logic [N-1:0] gl [0:LVLS];
  logic [N-1:0] pl [0:LVLS];

  assign gl[0] = g;
  assign pl[0] = p;

  for (genvar lv = 0; lv < LVLS; lv++) begin : g_lvl
    for (genvar i = 0; i < N; i++) begin : g_bit
      if (i >= (1 << lv)) begin : g_merge
        assign gl[lv+1][i] = gl[lv][i] | (pl[lv][i] & gl[lv][i-(1 << lv)]);
        assign pl[lv+1][i] = pl[lv][i] & pl[lv][i-(1 << lv)];
      end else begin : g_pass
        assign gl[lv+1][i] = gl[lv][i];
        assign pl[lv+1][i] = pl[lv][i];
      end
    end
  end

  // no carry enters the bottom digit
  assign carry = {gl[LVLS], 1'b0};

endmodule

`default_nettype wire

[rtl/core/sbas_lane_sum.sv]
// Back digit lane: decimal add or subtract of one digit with a known carry in.
// Depends on sbas_pkg.
`default_nettype none

module sbas_lane_sum (
  input  wire logic                         sub,
  input  wire logic [sbas_pkg::DIGIT_W-1:0] x,
  input  wire logic [sbas_pkg::DIGIT_W-1:0] y,
  input  wire logic                         cin,
  output logic [sbas_pkg::DIGIT_W-1:0]      digit
);

  logic [sbas_pkg::SUM_W-1:0] add_raw;
  logic [sbas_pkg::SUM_W-1:0] add_fix;
  logic [sbas_pkg::SUM_W-1:0] sub_raw;
  logic [sbas_pkg::SUM_W-1:0] sub_fix;

  always_comb begin
    add_raw = {1'b0, x} + {1'b0, y} + {{sbas_pkg::DIGIT_W{1'b0}}, cin};
    add_fix = (add_raw >= sbas_pkg::DEC_BASE) ? add_raw - sbas_pkg::DEC_BASE : add_raw;
    // top bit set means the difference went negative: add ten back
    sub_raw = {1'b0, x} - {1'b0, y} - {{sbas_pkg::DIGIT_W{1'b0}}, cin};
    sub_fix = sub_raw[sbas_pkg::DIGIT_W] ? sub_raw + sbas_pkg::DEC_BASE : sub_raw;
    digit   = sub ? sub_fix[sbas_pkg::DIGIT_W-1:0] : add_fix[sbas_pkg::DIGIT_W-1:0];
  end

endmodule

`default_nettype wire

[rtl/core/signed_bcd_add_subtract_unit.sv]
// Signed BCD add/subtract unit, sign-magnitude packed BCD operands.
// Requests pass the s1, s2 and result registers in order; throughput one request per cycle
// while results are taken, set by the three-stage lane/prefix/lane pipeline with one result register.
// rst (synchronous, active high) empties all stages; payload registers are not reset.
// Depends on sbas_pkg, sbas_if, sbas_lane_gp, sbas_carry_tree, sbas_lane_sum.
`default_nettype none

module signed_bcd_add_subtract_unit #(
  parameter int DIGITS = 16
) (
  input  wire logic   clk,
  input  wire logic   rst,
  sbas_op_if.sink     op,
  sbas_res_if.source  res
);

  localparam int DW = DIGITS * sbas_pkg::DIGIT_W;

  // ---------------------------------------------------------------------------
  // Pipeline control: each stage advances when its successor has room.
  // A result waiting in the output register does not block earlier stages
  // that still hold empty slots.
  // ---------------------------------------------------------------------------
  logic s1_valid;
  logic s2_valid;
  logic res_valid;
  logic adv1;
  logic adv2;
  logic adv3;

  assign adv3     = !res_valid || res.ready;
  assign adv2     = !s2_valid || adv3;
  assign adv1     = !s1_valid || adv2;
  assign op.ready = adv1;
  assign res.valid = res_valid;

  // ---------------------------------------------------------------------------
  // Stage 1: one front lane per digit computes carry and borrow terms.
  // Nibbles above DIGITS never enter the lanes, which drops them.
  // ---------------------------------------------------------------------------
  logic [DW-1:0]       in_a;
  logic [DW-1:0]       in_b;
  sbas_pkg::gp_t       in_gp [DIGITS];

  assign in_a = op.a_digits[DW-1:0];
  assign in_b = op.b_digits[DW-1:0];

  for (genvar i = 0; i < DIGITS; i++) begin : g_front
    sbas_lane_gp u_gp (
      .x  (in_a[i*sbas_pkg::DIGIT_W +: sbas_pkg::DIGIT_W]),
      .y  (in_b[i*sbas_pkg::DIGIT_W +: sbas_pkg::DIGIT_W]),
      .gp (in_gp[i])
    );
  end

  logic [DW-1:0]       s1_a;
  logic [DW-1:0]       s1_b;
  logic                s1_an;
  logic                s1_bn;
  sbas_pkg::gp_t       s1_gp [DIGITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv1) begin
      s1_valid <= op.valid;
    end
  end

  // subtract flips the second operand's sign
  always_ff @(posedge clk) begin
    if (adv1 && op.valid) begin
      s1_a  <= in_a;
      s1_b  <= in_b;
      s1_an <= op.a_negative;
      s1_bn <= op.b_negative ^ op.action;
      s1_gp <= in_gp;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: prefix trees merge the lane terms into digit carries for the
  // sum, a - b and b - a. The borrow out of a - b together with all-equal
  // digits decides which magnitude is larger.
  // ---------------------------------------------------------------------------
  logic [DIGITS-1:0] add_g;
  logic [DIGITS-1:0] add_p;
  logic [DIGITS-1:0] lt_v;
  logic [DIGITS-1:0] gt_v;
  logic [DIGITS-1:0] eq_v;
  logic [DIGITS:0]   c_add;
  logic [DIGITS:0]   c_ab;
  logic [DIGITS:0]   c_ba;

  for (genvar i = 0; i < DIGITS; i++) begin : g_unpack
    assign add_g[i] = s1_gp[i].add_g;
    assign add_p[i] = s1_gp[i].add_p;
    assign lt_v[i]  = s1_gp[i].lt;
    assign eq_v[i]  = s1_gp[i].eq;
    assign gt_v[i]  = !s1_gp[i].lt && !s1_gp[i].eq;
  end

  sbas_carry_tree #(.N(DIGITS)) u_tree_add (.g(add_g), .p(add_p), .carry(c_add));
  sbas_carry_tree #(.N(DIGITS)) u_tree_ab  (.g(lt_v),  .p(eq_v),  .carry(c_ab));
  sbas_carry_tree #(.N(DIGITS)) u_tree_ba  (.g(gt_v),  .p(eq_v),  .carry(c_ba));

  logic [DW-1:0]     s2_a;
  logic [DW-1:0]     s2_b;
  logic              s2_an;
  logic              s2_bn;
  logic              s2_a_gt;
  logic [DIGITS:0]   s2_c_add;
  logic [DIGITS-1:0] s2_c_ab;
  logic [DIGITS-1:0] s2_c_ba;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_valid) begin
      s2_a     <= s1_a;
      s2_b     <= s1_b;
      s2_an    <= s1_an;
      s2_bn    <= s1_bn;
      s2_a_gt  <= !c_ab[DIGITS] && !(&eq_v);
      s2_c_add <= c_add;
      s2_c_ab  <= c_ab[DIGITS-1:0];
      s2_c_ba  <= c_ba[DIGITS-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: back lanes form the result digits. Equal signs add; opposite
  // signs subtract the smaller magnitude from the larger. The borrow out of
  // the top digit is dropped.
  // ---------------------------------------------------------------------------
  logic              same_sign;
  logic [DW-1:0]     big;
  logic [DW-1:0]     little;
  logic [DIGITS-1:0] lane_cin;
  logic [DW-1:0]     mag;
  logic              mag_zero;
  logic              neg;

  assign same_sign = s2_an == s2_bn;
  assign big       = (same_sign || s2_a_gt) ? s2_a : s2_b;
  assign little    = (same_sign || s2_a_gt) ? s2_b : s2_a;
  assign lane_cin  = same_sign ? s2_c_add[DIGITS-1:0] : (s2_a_gt ? s2_c_ab : s2_c_ba);

  for (genvar i = 0; i < DIGITS; i++) begin : g_back
    sbas_lane_sum u_sum (
      .sub   (!same_sign),
      .x     (big[i*sbas_pkg::DIGIT_W +: sbas_pkg::DIGIT_W]),
      .y     (little[i*sbas_pkg::DIGIT_W +: sbas_pkg::DIGIT_W]),
      .cin   (lane_cin[i]),
      .digit (mag[i*sbas_pkg::DIGIT_W +: sbas_pkg::DIGIT_W])
    );
  end

  // zero is always positive, also a sum that wrapped to zero
  assign mag_zero = mag == '0;
  assign neg      = !mag_zero && ((same_sign || s2_a_gt) ? s2_an : s2_bn);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv3) begin
      res_valid <= s2_valid;
    end
  end

  // hold the result while the consumer stalls
  always_ff @(posedge clk) begin
    if (adv3 && s2_valid) begin
      res.sum_digits   <= sbas_pkg::WORD_W'(mag);
      res.sum_negative <= neg;
      res.overflow     <= same_sign && s2_c_add[DIGITS];
    end
  end

`ifndef NO_ASSERTIONS
  // a zero magnitude never carries a minus sign
  a_zero_positive: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.sum_negative |-> res.sum_digits != '0)
    else $error("negative zero on result");

  // digits above DIGITS stay clear
  a_upper_clear: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.sum_digits >> DW) == '0)
    else $error("result digits above DIGITS not zero");

  // a request taken into stage 1 is handed on when stage 2 has room
  a_stage_move: assert property (@(posedge clk) disable iff (rst)
    s1_valid && adv2 |=> s2_valid)
    else $error("request lost between stage 1 and stage 2");

  // overflow only arises on the addition path
  a_ovf_add: assert property (@(posedge clk) disable iff (rst)
    s2_valid && adv3 && !same_sign |=> !res.overflow)
    else $error("overflow flagged on subtraction");
`endif

endmodule

`default_nettype wire

[bench/tb_signed_bcd_add_subtract_unit.sv]
// Self-checking bench for signed_bcd_add_subtract_unit: random and directed requests,
// each result checked against an in-bench sign-magnitude BCD calculator.
// Depends on sbas_pkg, sbas_if and the unit itself.
`default_nettype none

module tb_signed_bcd_add_subtract_unit;

  localparam int DIGITS       = 16;
  localparam int W            = sbas_pkg::WORD_W;
  localparam int DIG_W        = sbas_pkg::DIGIT_W;
  localparam int LATENCY      = 3;
  localparam int DRAIN_CYCLES = LATENCY + 8;
  localparam int HOLD_CYCLES  = 120;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 10;

  localparam logic ACT_ADD = 1'b0;
  localparam logic ACT_SUB = 1'b1;

  localparam logic [W-1:0] ALL_NINES = 64'h9999_9999_9999_9999;
  localparam logic [W-1:0] ALL_F     = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic         action;
    logic [W-1:0] a_digits;
    logic         a_negative;
    logic [W-1:0] b_digits;
    logic         b_negative;
  } bcd_req_t;

  typedef struct packed {
    logic [W-1:0] sum_digits;
    logic         sum_negative;
    logic         overflow;
  } bcd_sum_t;

  logic clk;
  logic rst;

  sbas_op_if  op_ch ();
  sbas_res_if res_ch ();

  signed_bcd_add_subtract_unit #(
    .DIGITS(DIGITS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .op (op_ch.sink),
    .res(res_ch.source)
  );

  // Pending requests for the driver and sums still owed by the unit.
  bcd_req_t req_q[$];
  bcd_sum_t sum_q[$];

  int tx_idle_pct;
  int rx_idle_pct;
  logic hold_go;
  int hold_left;

  int mismatches;
  int checked;
  int n_overflow;
  int n_negative;
  int n_zero;
  int n_stalled;
  int cycle_cnt;

  // ------------------------------------------------------------------
  // Calculator: add or subtract two sign-magnitude packed BCD words.
  // ------------------------------------------------------------------
  function automatic bcd_sum_t calc_signed_bcd(bcd_req_t r);
    logic [W-1:0] mask;
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic [W-1:0] x;
    logic [W-1:0] y;
    logic [W-1:0] mag;
    logic         b_eff;
    logic         neg;
    logic         carry;
    logic [4:0]   s;
    int           d;
    int           borrow;
    bcd_sum_t     o;
    mask  = (DIGITS >= 16) ? ALL_F : ((64'd1 << (DIG_W * DIGITS)) - 64'd1);
    a     = r.a_digits & mask;
    b     = r.b_digits & mask;
    // Subtracting flips the second operand's sign.
    b_eff = r.b_negative ^ (r.action == ACT_SUB);
    mag   = '0;
    carry = 1'b0;
    if (r.a_negative == b_eff) begin
      // Same effective sign: add magnitudes with decimal carry, take a's sign.
      for (int k = 0; k < DIGITS; k++) begin
        s = {1'b0, a[DIG_W*k +: DIG_W]} + {1'b0, b[DIG_W*k +: DIG_W]} + {4'd0, carry};
        if (s >= 5'd10) begin
          s     = s - 5'd10;
          carry = 1'b1;
        end else begin
          carry = 1'b0;
        end
        mag[DIG_W*k +: DIG_W] = s[3:0];
      end
      neg = r.a_negative;
    end else begin
      // Opposite signs: larger minus smaller, sign of the larger; ties go to b.
      if (a > b) begin
        x   = a;
        y   = b;
        neg = r.a_negative;
      end else begin
        x   = b;
        y   = a;
        neg = b_eff;
      end
      borrow = 0;
      for (int k = 0; k < DIGITS; k++) begin
        d = int'(x[DIG_W*k +: DIG_W]) - int'(y[DIG_W*k +: DIG_W]) - borrow;
        if (d < 0) begin
          d      = d + 10;
          borrow = 1;
        end else begin
          borrow = 0;
        end
        mag[DIG_W*k +: DIG_W] = d[3:0];
      end
    end
    mag = mag & mask;
    // Zero is always positive, whether wrapped or from equal magnitudes.
    if (mag == '0) neg = 1'b0;
    o.sum_digits   = mag;
    o.sum_negative = neg;
    o.overflow     = carry;
    return o;
  endfunction

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------
  function automatic logic [W-1:0] rand_bcd(int ndig, int nine_pct);
    logic [W-1:0] v;
    v = '0;
    for (int k = 0; k < sbas_pkg::MAX_DIGITS; k++) begin
      if (k < ndig) begin
        if ($urandom_range(99) < nine_pct) v[DIG_W*k +: DIG_W] = 4'd9;
        else v[DIG_W*k +: DIG_W] = DIG_W'($urandom_range(9));
      end
    end
    return v;
  endfunction

  function automatic logic [W-1:0] rand_raw();
    return {$urandom(), $urandom()};
  endfunction

  function automatic bcd_req_t make_req(logic act, logic [W-1:0] a, logic an,
                                        logic [W-1:0] b, logic bn);
    bcd_req_t r;
    r.action     = act;
    r.a_digits   = a;
    r.a_negative = an;
    r.b_digits   = b;
    r.b_negative = bn;
    return r;
  endfunction

  // Mostly well-formed BCD with carry chains and near-equal magnitudes,
  // plus raw words whose nibbles run above nine.
  function automatic bcd_req_t rand_req();
    bcd_req_t r;
    int       kind;
    int       pos;
    kind         = $urandom_range(9);
    r.action     = 1'($urandom_range(1));
    r.a_negative = 1'($urandom_range(1));
    r.b_negative = 1'($urandom_range(1));
    case (kind)
      0, 1, 2: begin
        r.a_digits = rand_bcd($urandom_range(1, 16), 10);
        r.b_digits = rand_bcd($urandom_range(1, 16), 10);
      end
      3, 4: begin
        r.a_digits = rand_bcd(16, 80);
        r.b_digits = rand_bcd($urandom_range(1, 16), 60);
      end
      5, 6: begin
        // Equal or nearly equal magnitudes stress the compare and zero sign.
        r.a_digits = rand_bcd(16, 20);
        r.b_digits = r.a_digits;
        if ($urandom_range(1) == 1) begin
          pos = $urandom_range(15);
          r.b_digits[DIG_W*pos +: DIG_W] = DIG_W'($urandom_range(9));
        end
      end
      7: begin
        r.a_digits = rand_raw();
        r.b_digits = rand_raw();
      end
      8: begin
        r.a_digits = ($urandom_range(1) == 1) ? '0 : rand_bcd(16, 30);
        r.b_digits = ($urandom_range(1) == 1) ? '0 : rand_raw();
      end
      default: begin
        r.a_digits = rand_raw();
        r.b_digits = rand_bcd($urandom_range(1, 16), 50);
      end
    endcase
    return r;
  endfunction

  task automatic queue_directed();
    // zeros and negative zeros
    req_q.push_back(make_req(ACT_ADD, '0, 1'b0, '0, 1'b0));
    req_q.push_back(make_req(ACT_SUB, '0, 1'b1, '0, 1'b1));
    req_q.push_back(make_req(ACT_ADD, '0, 1'b1, '0, 1'b1));
    // wrap to zero with overflow, both signs, and an overflow that does not wrap to zero
    req_q.push_back(make_req(ACT_ADD, ALL_NINES, 1'b0, 64'd1, 1'b0));
    req_q.push_back(make_req(ACT_ADD, ALL_NINES, 1'b1, 64'd1, 1'b1));
    req_q.push_back(make_req(ACT_SUB, ALL_NINES, 1'b1, 64'd1, 1'b0));
    req_q.push_back(make_req(ACT_ADD, ALL_NINES, 1'b0, ALL_NINES, 1'b0));
    // digits above nine
    req_q.push_back(make_req(ACT_ADD, ALL_F, 1'b0, ALL_F, 1'b0));
    req_q.push_back(make_req(ACT_SUB, ALL_F, 1'b0, '0, 1'b0));
    req_q.push_back(make_req(ACT_SUB, '0, 1'b0, ALL_F, 1'b0));
    req_q.push_back(make_req(ACT_ADD, 64'hA0F5, 1'b1, 64'h0FAB, 1'b0));
    // equal magnitudes, opposite effective signs
    req_q.push_back(make_req(ACT_ADD, 64'h123, 1'b0, 64'h123, 1'b1));
    req_q.push_back(make_req(ACT_SUB, 64'h123, 1'b0, 64'h123, 1'b0));
    req_q.push_back(make_req(ACT_SUB, ALL_NINES, 1'b1, ALL_NINES, 1'b1));
    // smaller minus larger, both signs, then larger minus smaller with a borrow across zeros
    req_q.push_back(make_req(ACT_SUB, 64'h5, 1'b0, 64'h7, 1'b0));
    req_q.push_back(make_req(ACT_SUB, 64'h5, 1'b1, 64'h7, 1'b1));
    req_q.push_back(make_req(ACT_ADD, 64'h1000, 1'b0, 64'h1, 1'b1));
    // subtract of a negative adds; a negative plus a larger positive subtracts
    req_q.push_back(make_req(ACT_SUB, 64'h4567, 1'b0, 64'h5433, 1'b1));
    req_q.push_back(make_req(ACT_SUB, ALL_NINES, 1'b0, '0, 1'b1));
    req_q.push_back(make_req(ACT_ADD, 64'h1, 1'b1, ALL_NINES, 1'b0));
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) req_q.push_back(rand_req());
  endtask

  // Hold the sender until every request is in and every sum is out.
  // Look between edges, where the driver and monitor updates have settled.
  task automatic drain_all();
    while (req_q.size() != 0 || op_ch.valid || sum_q.size() != 0) @(negedge clk);
  endtask

  // ------------------------------------------------------------------
  // Clock, reset and input defaults
  // ------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst               = 1'b1;
    op_ch.valid       = 1'b0;
    op_ch.action      = 1'b0;
    op_ch.a_digits    = '0;
    op_ch.a_negative  = 1'b0;
    op_ch.b_digits    = '0;
    op_ch.b_negative  = 1'b0;
    res_ch.ready      = 1'b0;
    hold_go           = 1'b0;
    tx_idle_pct       = 19;
    rx_idle_pct       = 79;
  end

  // ------------------------------------------------------------------
  // Test sequence: directed and random requests in three phases of idling and stalls.
  // ------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Phase 1: sender idles lightly, receiver heavily.
    queue_directed();
    queue_random(540);
    drain_all();

    // Phase 2: swap the idling.
    tx_idle_pct = 79;
    rx_idle_pct = 19;
    queue_random(540);
    drain_all();

    // Phase 3: no idling; stall the receiver for a long stretch so the
    // unit fills and pushes back on the request side.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    queue_random(520);
    @(posedge clk);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    drain_all();

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d sums: %0d overflowed, %0d negative, %0d zero.",
             checked, n_overflow, n_negative, n_zero);
    $display("Request side stalled by the unit on %0d cycles; %0d mismatches.",
             n_stalled, mismatches);
    if (mismatches == 0 && sum_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // ------------------------------------------------------------------
  // Driver: offer the next pending request, with random gaps.
  // Predict the sum at the edge where the request is accepted.
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    bcd_req_t nxt;
    bcd_req_t taken;
    if (rst) begin
      op_ch.valid <= 1'b0;
    end else begin
      if (op_ch.valid && op_ch.ready) begin
        taken.action     = op_ch.action;
        taken.a_digits   = op_ch.a_digits;
        taken.a_negative = op_ch.a_negative;
        taken.b_digits   = op_ch.b_digits;
        taken.b_negative = op_ch.b_negative;
        sum_q.push_back(calc_signed_bcd(taken));
      end
      if (op_ch.valid && !op_ch.ready) n_stalled++;
      // Advance only when the current request was taken or none is offered.
      if (!op_ch.valid || op_ch.ready) begin
        if (req_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          nxt = req_q.pop_front();
          op_ch.action     <= nxt.action;
          op_ch.a_digits   <= nxt.a_digits;
          op_ch.a_negative <= nxt.a_negative;
          op_ch.b_digits   <= nxt.b_digits;
          op_ch.b_negative <= nxt.b_negative;
          op_ch.valid      <= 1'b1;
        end else begin
          op_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold, counted on its own.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver ready: drop it during the hold, otherwise idle at random.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (hold_go || hold_left > 1) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // ------------------------------------------------------------------
  // Monitor: compare each accepted sum with the oldest prediction.
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    bcd_sum_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (sum_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: unexpected sum digits=%h neg=%b ovf=%b",
                   res_ch.sum_digits, res_ch.sum_negative, res_ch.overflow);
      end else begin
        want = sum_q.pop_front();
        checked++;
        if (want.overflow) n_overflow++;
        if (want.sum_negative) n_negative++;
        if (want.sum_digits == '0) n_zero++;
        if (res_ch.sum_digits !== want.sum_digits ||
            res_ch.sum_negative !== want.sum_negative ||
            res_ch.overflow !== want.overflow) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("ERROR: sum #%0d expected digits=%h neg=%b ovf=%b, got digits=%h neg=%b ovf=%b",
                     checked, want.sum_digits, want.sum_negative, want.overflow,
                     res_ch.sum_digits, res_ch.sum_negative, res_ch.overflow);
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d sums outstanding", cycle_cnt, sum_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule

`default_nettype wire
